// ===== rtl/skte_pkg.sv =====
// ============================================================================
// skte_pkg
// Shared constants, codes and control types of the sorted key table engine.
// ============================================================================
package skte_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int KEY_W    = 32;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_LIST   = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUP       = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_POS_EMPTY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_INS_WRITE,
        S_LIST_RD,
        S_DELIVER
    } t_state;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_POS,
        RD_IDX_NEXT,
        RD_COUNT_M1,
        RD_PTR_M2
    } t_rd_sel;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_CLEAR,
        IDX_INC,
        IDX_COUNT
    } t_idx_op;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_COUNT,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT,
        WR_INSERT,
        WR_UPDATE
    } t_wr_op;

    typedef enum logic [3:0] {
        RES_NONE,
        RES_FULL,
        RES_NOT_FOUND,
        RES_POS_EMPTY,
        RES_DUP,
        RES_FOUND,
        RES_UPDATED,
        RES_INSERTED,
        RES_LIST
    } t_res_sel;

    // One table entry as held in the memory
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] qty;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic     load_item;
        logic     rd_en;
        t_rd_sel  rd_sel;
        t_idx_op  idx_op;
        t_ptr_op  ptr_op;
        t_wr_op   wr_op;
        logic     count_inc;
        t_res_sel res_sel;
        logic     out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_action action;
        logic    full;
        logic    empty;
        logic    pos_valid;
        logic    key_eq;
        logic    key_gt;
        logic    idx_last;
        logic    ptr_at_slot;
        logic    out_free;
    } t_stat;

endpackage

// ===== rtl/skte_if.sv =====
// ============================================================================
// skte_if
// Valid/ready channels of the sorted key table engine: request and result.
// ============================================================================
interface skte_in_if import skte_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [KEY_W-1:0] key_in;
    logic signed [KEY_W-1:0] amount;
    logic [IDX_W-1:0]        position;

    modport source (output valid, action, key_in, amount, position, input ready);
    modport sink   (input valid, action, key_in, amount, position, output ready);
endinterface

interface skte_out_if import skte_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic [IDX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0] key_out;
    logic signed [KEY_W-1:0] quantity_out;
    logic [CNT_W-1:0]        count_out;

    modport source (output valid, status, entry_index, key_out, quantity_out, count_out,
                    input ready);
    modport sink   (input valid, status, entry_index, key_out, quantity_out, count_out,
                    output ready);
endinterface

// ===== rtl/skte_ctrl.sv =====
// ============================================================================
// skte_ctrl
// Sequencer: dispatches one request, walks the table, shifts on insert and
// hands the result to the output register.
// ============================================================================
module skte_ctrl import skte_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.rd_sel  = RD_ZERO;
        o_cmd.idx_op  = IDX_HOLD;
        o_cmd.ptr_op  = PTR_HOLD;
        o_cmd.wr_op   = WR_NONE;
        o_cmd.res_sel = RES_NONE;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                o_cmd.idx_op = IDX_CLEAR;
                case (i_stat.action)
                    ACT_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.res_sel = RES_FULL;
                            n_state       = S_DELIVER;
                        end else if (i_stat.empty) begin
                            n_state = S_INS_WRITE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_SCAN;
                        end
                    end
                    ACT_LIST: begin
                        if (i_stat.pos_valid) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_POS;
                            n_state      = S_LIST_RD;
                        end else begin
                            o_cmd.res_sel = RES_POS_EMPTY;
                            n_state       = S_DELIVER;
                        end
                    end
                    default: begin
                        if (i_stat.empty) begin
                            o_cmd.res_sel = RES_NOT_FOUND;
                            n_state       = S_DELIVER;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_SCAN;
                        end
                    end
                endcase
            end

            // Compare one stored entry per cycle, stop early on the sorted order
            S_SCAN: begin
                if (i_stat.key_eq) begin
                    case (i_stat.action)
                        ACT_INSERT: o_cmd.res_sel = RES_DUP;
                        ACT_UPDATE: begin
                            o_cmd.wr_op   = WR_UPDATE;
                            o_cmd.res_sel = RES_UPDATED;
                        end
                        default:    o_cmd.res_sel = RES_FOUND;
                    endcase
                    n_state = S_DELIVER;
                end else if (i_stat.key_gt) begin
                    if (i_stat.action == ACT_INSERT) begin
                        o_cmd.ptr_op = PTR_COUNT;
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_COUNT_M1;
                        n_state      = S_SHIFT;
                    end else begin
                        o_cmd.res_sel = RES_NOT_FOUND;
                        n_state       = S_DELIVER;
                    end
                end else if (i_stat.idx_last) begin
                    if (i_stat.action == ACT_INSERT) begin
                        o_cmd.idx_op = IDX_COUNT;
                        n_state      = S_INS_WRITE;
                    end else begin
                        o_cmd.res_sel = RES_NOT_FOUND;
                        n_state       = S_DELIVER;
                    end
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_NEXT;
                end
            end

            // Move entries up by one, top first, one per cycle
            S_SHIFT: begin
                o_cmd.wr_op = WR_SHIFT;
                if (i_stat.ptr_at_slot) begin
                    n_state = S_INS_WRITE;
                end else begin
                    o_cmd.ptr_op = PTR_DEC;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PTR_M2;
                end
            end

            S_INS_WRITE: begin
                o_cmd.wr_op     = WR_INSERT;
                o_cmd.count_inc = 1'b1;
                o_cmd.res_sel   = RES_INSERTED;
                n_state         = S_DELIVER;
            end

            S_LIST_RD: begin
                o_cmd.res_sel = RES_LIST;
                n_state       = S_DELIVER;
            end

            // Wait for a free output register
            S_DELIVER: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/skte_dpath.sv =====
// ============================================================================
// skte_dpath
// Entry memory, count, walk pointers, saturating adder, result staging and
// output register.
// ============================================================================
module skte_dpath import skte_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic [ACT_W-1:0]        i_action,
    input  logic signed [KEY_W-1:0] i_key_in,
    input  logic signed [KEY_W-1:0] i_amount,
    input  logic [IDX_W-1:0]        i_position,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [STAT_W-1:0]       o_status,
    output logic [IDX_W-1:0]        o_entry_index,
    output logic signed [KEY_W-1:0] o_key_out,
    output logic signed [KEY_W-1:0] o_quantity_out,
    output logic [CNT_W-1:0]        o_count_out
);

    // Request registers
    t_action                 r_action;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_amount;
    logic [IDX_W-1:0]        r_position;

    // Walk state and table count
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_count;

    // Entry memory
    t_entry           mem [CAPACITY];
    t_entry           r_rdata;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    // Result staging and output register
    t_status                 r_res_status;
    logic [IDX_W-1:0]        r_res_index;
    logic signed [KEY_W-1:0] r_res_key;
    logic signed [KEY_W-1:0] r_res_qty;
    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_out_status;
    logic [IDX_W-1:0]        r_out_index;
    logic signed [KEY_W-1:0] r_out_key;
    logic signed [KEY_W-1:0] r_out_qty;
    logic [CNT_W-1:0]        r_out_count;

    logic [KEY_W:0]          sum;
    logic signed [KEY_W-1:0] sat_qty;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action   <= t_action'(i_action);
            r_key      <= i_key_in;
            r_amount   <= i_amount;
            r_position <= i_position;
        end
    end

    // Scan index (doubles as insert slot) and shift pointer
    always_ff @(posedge i_clk) begin
        case (i_cmd.idx_op)
            IDX_CLEAR: r_idx <= '0;
            IDX_INC:   r_idx <= r_idx + IDX_W'(1);
            IDX_COUNT: r_idx <= r_count[IDX_W-1:0];
            default:   r_idx <= r_idx;
        endcase
        case (i_cmd.ptr_op)
            PTR_COUNT: r_ptr <= r_count[IDX_W-1:0];
            PTR_DEC:   r_ptr <= r_ptr - IDX_W'(1);
            default:   r_ptr <= r_ptr;
        endcase
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.count_inc) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Saturating add of the stored quantity and the delta
    always_comb begin
        sum = {r_rdata.qty[KEY_W-1], r_rdata.qty} + {r_amount[KEY_W-1], r_amount};
        if (sum[KEY_W] != sum[KEY_W-1]) begin
            sat_qty = sum[KEY_W] ? {1'b1, {(KEY_W-1){1'b0}}} : {1'b0, {(KEY_W-1){1'b1}}};
        end else begin
            sat_qty = sum[KEY_W-1:0];
        end
    end

    // Memory address and data selection
    always_comb begin
        case (i_cmd.rd_sel)
            RD_POS:      rd_addr = r_position;
            RD_IDX_NEXT: rd_addr = r_idx + IDX_W'(1);
            RD_COUNT_M1: rd_addr = r_count[IDX_W-1:0] - IDX_W'(1);
            RD_PTR_M2:   rd_addr = r_ptr - IDX_W'(2);
            default:     rd_addr = '0;
        endcase
        wr_en   = 1'b1;
        wr_addr = r_idx;
        wr_data = r_rdata;
        case (i_cmd.wr_op)
            WR_SHIFT:  wr_addr = r_ptr;
            WR_INSERT: wr_data = '{key: r_key, qty: r_amount};
            WR_UPDATE: wr_data = '{key: r_rdata.key, qty: sat_qty};
            default:   wr_en = 1'b0;
        endcase
    end

    // Memory write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Memory read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Stage the result of the request
    always_ff @(posedge i_clk) begin
        case (i_cmd.res_sel)
            RES_FULL: begin
                r_res_status <= ST_FULL;
                r_res_index  <= '0;
                r_res_key    <= r_key;
                r_res_qty    <= '0;
            end
            RES_NOT_FOUND: begin
                r_res_status <= ST_NOT_FOUND;
                r_res_index  <= '0;
                r_res_key    <= r_key;
                r_res_qty    <= '0;
            end
            RES_POS_EMPTY: begin
                r_res_status <= ST_POS_EMPTY;
                r_res_index  <= r_position;
                r_res_key    <= '0;
                r_res_qty    <= '0;
            end
            RES_DUP: begin
                r_res_status <= ST_DUP;
                r_res_index  <= r_idx;
                r_res_key    <= r_rdata.key;
                r_res_qty    <= r_rdata.qty;
            end
            RES_FOUND: begin
                r_res_status <= ST_OK;
                r_res_index  <= r_idx;
                r_res_key    <= r_rdata.key;
                r_res_qty    <= r_rdata.qty;
            end
            RES_UPDATED: begin
                r_res_status <= ST_OK;
                r_res_index  <= r_idx;
                r_res_key    <= r_rdata.key;
                r_res_qty    <= sat_qty;
            end
            RES_INSERTED: begin
                r_res_status <= ST_OK;
                r_res_index  <= r_idx;
                r_res_key    <= r_key;
                r_res_qty    <= r_amount;
            end
            RES_LIST: begin
                r_res_status <= ST_OK;
                r_res_index  <= r_position;
                r_res_key    <= r_rdata.key;
                r_res_qty    <= r_rdata.qty;
            end
            default: begin
                r_res_status <= r_res_status;
            end
        endcase
    end

    // Output register: load on command, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_index  <= r_res_index;
            r_out_key    <= r_res_key;
            r_out_qty    <= r_res_qty;
            r_out_count  <= r_count;
        end
    end

    // Status toward the controller
    always_comb begin
        o_stat.action      = r_action;
        o_stat.full        = (r_count == CNT_W'(CAPACITY));
        o_stat.empty       = (r_count == '0);
        o_stat.pos_valid   = ({1'b0, r_position} < r_count);
        o_stat.key_eq      = (r_rdata.key == r_key);
        o_stat.key_gt      = (r_rdata.key > r_key);
        o_stat.idx_last    = ({1'b0, r_idx} == (r_count - CNT_W'(1)));
        o_stat.ptr_at_slot = ((r_ptr - IDX_W'(1)) == r_idx);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_entry_index  = r_out_index;
    assign o_key_out      = r_out_key;
    assign o_quantity_out = r_out_qty;
    assign o_count_out    = r_out_count;

endmodule

// ===== rtl/sorted_key_table_engine_top.sv =====
// ============================================================================
// sorted_key_table_engine_top
// Table of up to 64 signed key/quantity pairs kept in ascending key order.
// ============================================================================
// Usage:
//   i_in carries one request (insert, search, update, list) per transfer;
//   o_out returns exactly one result per request, in request order.
//   Requests are handled one at a time: i_in.ready is high only while the
//   sequencer is idle. The walk through the entry memory sets the latency,
//   one stored entry per cycle on its single read and single write port.
//   A search or update walk stops at the matching or first larger key; an
//   insert walks to its slot, then shifts the entries above it up by one;
//   a list reads the entry at its position directly.
//   A finished result sits in an output register; while o_out.ready stays
//   low the result holds and the next request is still taken, but its own
//   result waits until the register frees.
//   Reset empties the table (count to zero) and drops any pending result;
//   memory contents are not cleared and are never read before written.
// ============================================================================
module sorted_key_table_engine_top import skte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    skte_in_if.sink     i_in,
    skte_out_if.source  o_out
);

    t_cmd  cmd;
    t_stat stat;

    skte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    skte_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_action       (i_in.action),
        .i_key_in       (i_in.key_in),
        .i_amount       (i_in.amount),
        .i_position     (i_in.position),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_status       (o_out.status),
        .o_entry_index  (o_out.entry_index),
        .o_key_out      (o_out.key_out),
        .o_quantity_out (o_out.quantity_out),
        .o_count_out    (o_out.count_out)
    );

endmodule

// ===== rtl/skte_checker.sv =====
// ============================================================================
// skte_checker
// Port-level checks of the sorted key table engine, bound to the top level.
// ============================================================================
module skte_checker import skte_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [STAT_W-1:0]       i_status,
    input logic [IDX_W-1:0]        i_entry_index,
    input logic signed [KEY_W-1:0] i_key_out,
    input logic signed [KEY_W-1:0] i_quantity_out,
    input logic [CNT_W-1:0]        i_count_out
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_entry_index) && $stable(i_key_out)
            && $stable(i_quantity_out) && $stable(i_count_out))
        else $error("stalled result changed");

    // One request at a time: a transfer closes the request channel
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while another is in progress");

    // Table full is reported only with a full count
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_count_out == CNT_W'(CAPACITY))
        else $error("table full reported below capacity");

    // Count never exceeds capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_count_out <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

endmodule

bind sorted_key_table_engine_top skte_checker u_skte_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_entry_index  (o_out.entry_index),
    .i_key_out      (o_out.key_out),
    .i_quantity_out (o_out.quantity_out),
    .i_count_out    (o_out.count_out)
);
